FILE: sv/sgbm_pkg.sv
// shared constants, codes and types of the spectral gaussian band-pass mask
package sgbm_pkg;

  // sizing
  localparam int unsigned MAX_SIZE       = 1024;
  localparam int unsigned GAIN_FRAC_BITS = 16;
  localparam int unsigned HALF_SIZE      = MAX_SIZE / 2;
  localparam int unsigned TABLE_DEPTH    = HALF_SIZE + 1;
  localparam int unsigned IDX_W          = $clog2(TABLE_DEPTH);
  localparam int unsigned MAX_LOG2       = $clog2(MAX_SIZE);
  localparam int unsigned NW             = MAX_LOG2 + 1;
  localparam int unsigned GAIN_W         = GAIN_FRAC_BITS + 1;
  localparam int unsigned PROD_W         = 2 * GAIN_W;

  // field widths of the channels
  localparam int unsigned CMD_W    = 1;
  localparam int unsigned TSEL_W   = 2;
  localparam int unsigned TIDX_W   = 10;
  localparam int unsigned TVAL_W   = 17;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned COEF_W   = 32;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned SIZE_W   = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 4;
  localparam int unsigned MUL_W    = COEF_W + GAIN_W + 1;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_LOG2);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 1'b0,
    CMD_FILTER = 1'b1
  } cmd_e;

  typedef enum logic [TSEL_W-1:0] {
    TSEL_LARGE  = 2'd0,
    TSEL_SMALL  = 2'd1,
    TSEL_STRIPE = 2'd2
  } tsel_e;

  typedef enum logic [MODE_W-1:0] {
    STRIPE_NONE  = 2'd0,
    STRIPE_HORIZ = 2'd1,
    STRIPE_VERT  = 2'd2
  } stripe_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STRIPE_MODE = 1'b0,
    CFG_SIZE_LOG2   = 1'b1
  } cfg_idx_e;

  // one classified operation as it waits in the queue
  typedef struct packed {
    logic                     is_load;
    tsel_e                    sel;
    logic [IDX_W-1:0]         addr_r;
    logic [IDX_W-1:0]         addr_c;
    logic [GAIN_W-1:0]        value;
    logic                     dc;
    logic signed [COEF_W-1:0] coef;
  } sgbm_op_t;

endpackage

FILE: sv/sgbm_in_if.sv
// input channel: table loads and coefficients to filter
interface sgbm_in_if;
  logic                                      valid;
  logic                                      ready;
  logic [sgbm_pkg::CMD_W-1:0]                command;
  logic [sgbm_pkg::TSEL_W-1:0]               table_select;
  logic [sgbm_pkg::TIDX_W-1:0]               table_index;
  logic [sgbm_pkg::TVAL_W-1:0]               table_value;
  logic [sgbm_pkg::POS_W-1:0]                row_index;
  logic [sgbm_pkg::POS_W-1:0]                col_index;
  logic signed [sgbm_pkg::COEF_W-1:0]        coefficient;

  modport source (
    output valid, command, table_select, table_index, table_value,
           row_index, col_index, coefficient,
    input  ready
  );

  modport sink (
    input  valid, command, table_select, table_index, table_value,
           row_index, col_index, coefficient,
    output ready
  );
endinterface

FILE: sv/sgbm_out_if.sv
// output channel: filtered coefficients with their gain
interface sgbm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sgbm_pkg::COEF_W-1:0] filtered_coefficient;
  logic [sgbm_pkg::TVAL_W-1:0]        gain;

  modport source (
    output valid, filtered_coefficient, gain,
    input  ready
  );

  modport sink (
    input  valid, filtered_coefficient, gain,
    output ready
  );
endinterface

FILE: sv/sgbm_front.sv
// front end: accepts beats, folds positions, screens table loads
module sgbm_front (
  sgbm_in_if.sink                       in_if,
  input  logic [sgbm_pkg::SIZE_W-1:0]   size_log2_i,
  input  logic                          full_i,
  output logic                          push_o,
  output sgbm_pkg::sgbm_op_t            op_o
);
  import sgbm_pkg::*;

  logic [SIZE_W-1:0] lg;
  logic [NW-1:0]     n;
  logic [IDX_W-1:0]  kr;
  logic [IDX_W-1:0]  kc;
  logic              is_load;
  logic              load_ok;
  logic              sel_ok;
  logic              accept;

  // fold a position into 0..n/2
  function automatic logic [IDX_W-1:0] fold(input logic [POS_W-1:0] x,
                                            input logic [NW-1:0] nn);
    logic [NW-1:0] xm;
    logic [NW-1:0] k;
    xm = NW'(x) & (nn - NW'(1));
    k  = (xm <= (nn >> 1)) ? xm : nn - xm;
    return IDX_W'(k);
  endfunction

  // clamp size and build n
  always_comb begin
    if (size_log2_i < SIZE_W'(1)) begin
      lg = SIZE_W'(1);
    end else if (32'(size_log2_i) > MAX_LOG2) begin
      lg = SIZE_W'(MAX_LOG2);
    end else begin
      lg = size_log2_i;
    end
    n = NW'(1) << lg;
  end

  assign kr = fold(in_if.row_index, n);
  assign kc = fold(in_if.col_index, n);

  // load screening: known table and index in range
  always_comb begin
    case (in_if.table_select)
      TSEL_LARGE, TSEL_SMALL, TSEL_STRIPE: sel_ok = 1'b1;
      default:                             sel_ok = 1'b0;
    endcase
  end

  assign is_load = (in_if.command == CMD_LOAD);
  assign load_ok = sel_ok && (32'(in_if.table_index) <= HALF_SIZE);

  // handshake and queue push
  assign in_if.ready = !full_i;
  assign accept      = in_if.valid && in_if.ready;
  assign push_o      = accept && (!is_load || load_ok);

  // classified operation
  always_comb begin
    op_o.is_load = is_load;
    op_o.sel     = tsel_e'(in_if.table_select);
    op_o.addr_r  = is_load ? IDX_W'(in_if.table_index) : kr;
    op_o.addr_c  = kc;
    op_o.value   = (32'(in_if.table_value) > 32'(GAIN_ONE)) ? GAIN_ONE
                                                            : GAIN_W'(in_if.table_value);
    op_o.dc      = (kr == '0) && (kc == '0);
    op_o.coef    = in_if.coefficient;
  end

endmodule

FILE: sv/sgbm_queue.sv
// small fifo that decouples the front end from the gain pipeline
module sgbm_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sgbm_pkg::sgbm_op_t op_i,
  output logic               full_o,
  input  logic               pop_i,
  output sgbm_pkg::sgbm_op_t op_o,
  output logic               empty_o
);
  import sgbm_pkg::*;

  sgbm_op_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;

  assign full_o  = (32'(count_q) == QUEUE_DEPTH);
  assign empty_o = (count_q == '0);
  assign op_o    = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + (QPTR_W+1)'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue pop while empty");

endmodule

FILE: sv/sgbm_back.sv
// back end: gain tables and the stalling multiply pipeline
module sgbm_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sgbm_pkg::MODE_W-1:0]   stripe_mode_i,
  input  sgbm_pkg::sgbm_op_t            op_i,
  input  logic                          op_valid_i,
  output logic                          pop_o,
  sgbm_out_if.source                    out_if
);
  import sgbm_pkg::*;

  // gain tables
  logic [GAIN_W-1:0] large_mem  [TABLE_DEPTH];
  logic [GAIN_W-1:0] small_mem  [TABLE_DEPTH];
  logic [GAIN_W-1:0] stripe_mem [TABLE_DEPTH];

  logic adv;
  logic issue;
  logic [IDX_W-1:0] t_addr;
  logic stripe_on;

  // stage registers
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic dc1_q, dc2_q, dc3_q, dc4_q, dc5_q;
  logic signed [COEF_W-1:0] coef1_q, coef2_q, coef3_q, coef4_q, coef5_q;
  logic [GAIN_W-1:0] lr1_q, lc1_q, sr1_q, sc1_q, t1_q;
  logic [GAIN_W-1:0] sr2_q, sc2_q, t2_q;
  logic [GAIN_W-1:0] sc3_q, t3_q;
  logic [GAIN_W-1:0] t4_q;
  logic [PROD_W-1:0] p2_q, p3_q, p4_q, p5_q;
  logic [PROD_W-1:0] p2_d, p3_d, p4_d, p5_d;
  logic [GAIN_W-1:0] g3, g4, g5, g6, fac5;
  logic [GAIN_W-1:0] gain6_q;
  logic signed [MUL_W-1:0] p6_q, p6_d;

  // output register
  logic                     out_valid_q;
  logic signed [COEF_W-1:0] out_coef_q;
  logic [GAIN_W-1:0]        out_gain_q;

  // truncate a q product back to q16
  function automatic logic [GAIN_W-1:0] qtrunc(input logic [PROD_W-1:0] p);
    return p[GAIN_FRAC_BITS +: GAIN_W];
  endfunction

  // pipeline moves when the output register is free or being taken
  assign adv       = !out_valid_q || out_if.ready;
  assign pop_o     = adv && op_valid_i;
  assign issue     = pop_o && !op_i.is_load;
  assign stripe_on = (stripe_mode_i == STRIPE_HORIZ) || (stripe_mode_i == STRIPE_VERT);
  assign t_addr    = (stripe_mode_i == STRIPE_VERT) ? op_i.addr_r : op_i.addr_c;

  // table writes from load beats
  always_ff @(posedge clk_i) begin
    if (pop_o && op_i.is_load) begin
      case (op_i.sel)
        TSEL_LARGE:  large_mem[op_i.addr_r]  <= op_i.value;
        TSEL_SMALL:  small_mem[op_i.addr_r]  <= op_i.value;
        TSEL_STRIPE: stripe_mem[op_i.addr_r] <= op_i.value;
        default: ;
      endcase
    end
  end

  // table reads, registered
  always_ff @(posedge clk_i) begin
    if (adv) begin
      lr1_q   <= large_mem[op_i.addr_r];
      lc1_q   <= large_mem[op_i.addr_c];
      sr1_q   <= small_mem[op_i.addr_r];
      sc1_q   <= small_mem[op_i.addr_c];
      t1_q    <= stripe_mem[t_addr];
      dc1_q   <= op_i.dc;
      coef1_q <= op_i.coef;
    end
  end

  // multiply chain, one product per stage
  assign p2_d = PROD_W'(lr1_q) * PROD_W'(lc1_q);
  assign g3   = GAIN_ONE - qtrunc(p2_q);
  assign p3_d = PROD_W'(g3) * PROD_W'(sr2_q);
  assign g4   = qtrunc(p3_q);
  assign p4_d = PROD_W'(g4) * PROD_W'(sc3_q);
  assign g5   = qtrunc(p4_q);
  assign fac5 = stripe_on ? GAIN_ONE - t4_q : GAIN_ONE;
  assign p5_d = PROD_W'(g5) * PROD_W'(fac5);
  assign g6   = dc5_q ? GAIN_ONE : qtrunc(p5_q);
  assign p6_d = $signed(coef5_q) * $signed({1'b0, g6});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_q    <= p2_d;
      sr2_q   <= sr1_q;
      sc2_q   <= sc1_q;
      t2_q    <= t1_q;
      dc2_q   <= dc1_q;
      coef2_q <= coef1_q;

      p3_q    <= p3_d;
      sc3_q   <= sc2_q;
      t3_q    <= t2_q;
      dc3_q   <= dc2_q;
      coef3_q <= coef2_q;

      p4_q    <= p4_d;
      t4_q    <= t3_q;
      dc4_q   <= dc3_q;
      coef4_q <= coef3_q;

      p5_q    <= p5_d;
      dc5_q   <= dc4_q;
      coef5_q <= coef4_q;

      p6_q    <= p6_d;
      gain6_q <= g6;

      out_coef_q <= p6_q[GAIN_FRAC_BITS +: COEF_W];
      out_gain_q <= gain6_q;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= issue;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      out_valid_q <= v6_q;
    end
  end

  assign out_if.valid                = out_valid_q;
  assign out_if.filtered_coefficient = out_coef_q;
  assign out_if.gain                 = TVAL_W'(out_gain_q);

  a_last_stage_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v6_q && adv |=> out_valid_q)
    else $error("result lost between last stage and output register");

  a_gain_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_gain_q <= GAIN_ONE)
    else $error("gain above one");

  a_load_gives_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && op_i.is_load |=> !v1_q)
    else $error("table load entered the result pipeline");

endmodule

FILE: sv/spectral_gaussian_bandpass_mask.sv
// top level: configuration registers, front end, queue and gain pipeline
//
// Usage: in_if carries two kinds of beats. A load beat (command 0) writes one
// entry of the large, small or stripe Gaussian table at a folded frequency;
// values above one are saturated, loads to an unknown table or past 512 are
// dropped. A filter beat (command 1) carries a row, a column and a Hartley
// coefficient and produces exactly one beat on out_if with the filtered
// coefficient and the Q16 gain applied; the DC position passes unchanged.
// Load beats produce nothing on out_if but stay in order with filter beats.
// Tables must be loaded before they are read; they are not cleared by reset.
// Configuration (stripe mode, size_log2) is written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user must write it only while no beat is in
// flight, as the block itself does not enforce this. A filter beat passes
// through the queue, the registered table read, four gain multiplies, the
// coefficient multiply and the output register on its way to out_if.
// Throughput: one beat per cycle while out_if does not stall, set by the
// single-issue pipeline with one multiplier per multiply stage.
// A stall on out_if freezes the pipeline; the 4-entry queue keeps taking
// beats until it fills, then in_if.ready drops. Reset empties the queue and
// pipeline and sets stripe mode to none and size_log2 to its maximum.
module spectral_gaussian_bandpass_mask (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sgbm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sgbm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sgbm_in_if.sink                         in_if,
  sgbm_out_if.source                      out_if
);
  import sgbm_pkg::*;

  logic [MODE_W-1:0] stripe_mode_q;
  logic [SIZE_W-1:0] size_log2_q;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  sgbm_op_t q_in;
  sgbm_op_t q_out;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stripe_mode_q <= STRIPE_NONE;
      size_log2_q   <= SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STRIPE_MODE: stripe_mode_q <= cfg_data_i[MODE_W-1:0];
        CFG_SIZE_LOG2:   size_log2_q   <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // classify incoming beats
  sgbm_front u_front (
    .in_if       (in_if),
    .size_log2_i (size_log2_q),
    .full_i      (q_full),
    .push_o      (q_push),
    .op_o        (q_in)
  );

  // decoupling queue
  sgbm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .op_o    (q_out),
    .empty_o (q_empty)
  );

  // tables and gain pipeline
  sgbm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stripe_mode_i (stripe_mode_q),
    .op_i          (q_out),
    .op_valid_i    (!q_empty),
    .pop_o         (q_pop),
    .out_if        (out_if)
  );

endmodule
